// ----- src/byte_ring_fifo_unit_assert.svh -----
// Assertion macros shared by the byte ring FIFO RTL.
`ifndef BYTE_RING_FIFO_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_UNIT_ASSERT_SVH

// Invariant checked at every clock edge outside reset.
`define BRF_CHK(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BRF_CHK_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/brf_pkg.sv -----
// Types and constants shared by the byte ring FIFO modules.
package brf_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2,
    OP_CLR = 2'd3
  } brf_op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } brf_state_t;

  // One result as held in the output queue
  typedef struct packed {
    logic [7:0] data;
    logic [8:0] amount;
    logic       bvalid;
    logic       last;
  } brf_item_t;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

endpackage

// ----- src/brf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/brf_out_fifo.sv -----
// Small result queue that decouples the controller from the output stall.
module brf_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  brf_pkg::brf_item_t        push_item,
  input  logic                      pop,
  output logic [brf_pkg::OQ_CW-1:0] cnt,
  output brf_pkg::brf_item_t        head_item
);

  import brf_pkg::*;

  brf_item_t          entry_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OQ_CW'(push) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign cnt       = cnt_r;
  assign head_item = entry_r[rd_ptr_r];

endmodule

// ----- src/byte_ring_fifo_unit.sv -----
// Top level of the byte ring FIFO: controller, byte store and result queue.
// Usage:
//  - Input channel (in_valid / in_stall) carries one command per transfer:
//    add a byte, get up to in_count bytes (optionally as a peek), delete up
//    to in_count bytes, or clear both indices.
//  - Result channel (out_valid / out_stall) returns one result per add,
//    delete or clear, and one result per byte for a get (at most MAX_BURST;
//    a get that yields nothing returns a single empty result). out_last
//    marks the final result of each command.
//  - cfg_valid / cfg_ready writes cyclic_mode; cfg_ready is always high.
//    Write it only while no command is in flight.
//  - Add, delete and clear finish in the accept cycle; their result is
//    visible in the next cycle; back-to-back adds run at one per cycle while
//    the queue has room. A get holds the input for the accept cycle, a setup
//    step that clamps the fill level and sizes the burst, one store read per
//    cycle while the queue has room (the single read port sets that rate),
//    and a step for the last read data to land. A get yielding nothing ends in setup.
//  - A four-entry result queue absorbs out_stall; commands keep being taken
//    while results wait, until the queue is full.
//  - Reset clears both indices, sets cyclic_mode and empties the queue. The
//    byte store is not cleared.
module byte_ring_fifo_unit #(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_cyclic_mode,
  // Command channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data_in,
  input  logic [8:0] in_count,
  input  logic       in_peek,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic [8:0] out_amount,
  output logic       out_byte_valid,
  output logic       out_last
);

  import brf_pkg::*;

  localparam int          AW      = $clog2(DEPTH);
  localparam int          NW      = $clog2(MAX_BURST + 1);
  localparam logic [15:0] DEPTH16 = 16'(DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(DEPTH);
  localparam logic [8:0]  BURST9  = 9'(MAX_BURST);

  brf_state_t       state_r, state_nxt;
  logic [15:0]      wr_r, wr_nxt;
  logic [15:0]      rd_r, rd_nxt;
  logic [15:0]      fill_r, fill_nxt;     // always wr_r - rd_r
  logic             cyc_r;
  logic [8:0]       count_r;
  logic             peek_r;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    i_r, i_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             pend_r;               // read data lands this cycle
  logic             last_pend_r;

  brf_op_t          op;
  logic             accept;
  logic             add_ok;
  logic [16:0]      used17;
  logic [8:0]       del_n;
  logic             adjust;
  logic [15:0]      base;
  logic [16:0]      avail17;
  logic [8:0]       burst_cap;
  logic [16:0]      n_full;
  logic [NW-1:0]    n_setup;
  logic             rd_issue;
  logic             issue_last;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             push;
  brf_item_t        push_item;
  logic             pop;
  logic [OQ_CW-1:0] q_cnt;
  logic             q_room;
  brf_item_t        head_item;

  assign op       = brf_op_t'(in_mode);
  assign q_room   = q_cnt < OQ_CW'(OQ_DEPTH);
  assign in_stall = !(state_r == ST_IDLE && !pend_r && q_room);
  assign accept   = in_valid && !in_stall;

  // Add: free space check depends on the wrap mode
  assign used17 = cyc_r ? {1'b0, fill_r} : {1'b0, wr_r};
  assign add_ok = used17 < DEPTH17;

  // Delete: clamp to the fill level only
  assign del_n = (fill_r < {7'b0, in_count}) ? fill_r[8:0] : in_count;

  // Get sizing: clamp fill level to the store depth, then to count and burst
  assign adjust    = fill_r > DEPTH16;
  assign base      = adjust ? (wr_r - DEPTH16) : rd_r;
  assign avail17   = adjust ? DEPTH17 : {1'b0, fill_r};
  assign burst_cap = (count_r < BURST9) ? count_r : BURST9;
  assign n_full    = (avail17 < {8'b0, burst_cap}) ? avail17 : {8'b0, burst_cap};
  assign n_setup   = n_full[NW-1:0];

  assign issue_last = (i_r + NW'(1)) == n_r;

  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    addr_nxt  = addr_r;
    ram_we    = 1'b0;
    rd_issue  = 1'b0;
    push      = 1'b0;
    push_item = '0;
    push_item.last = 1'b1;

    // Landing read data of a get burst
    if (pend_r) begin
      push             = 1'b1;
      push_item.data   = ram_rdata;
      push_item.amount = 9'(n_r);
      push_item.bvalid = 1'b1;
      push_item.last   = last_pend_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_ADD: begin
              push             = 1'b1;
              push_item.amount = {8'b0, add_ok};
              if (add_ok) begin
                ram_we   = 1'b1;
                wr_nxt   = wr_r + 16'd1;
                fill_nxt = fill_r + 16'd1;
              end
            end
            OP_GET: begin
              state_nxt = ST_SETUP;
            end
            OP_DEL: begin
              push             = 1'b1;
              push_item.amount = del_n;
              rd_nxt           = rd_r + 16'(del_n);
              fill_nxt         = fill_r - 16'(del_n);
            end
            OP_CLR: begin
              push     = 1'b1;
              wr_nxt   = '0;
              rd_nxt   = '0;
              fill_nxt = '0;
            end
          endcase
        end
      end
      ST_SETUP: begin
        // Drop overrun bytes even for a peek
        rd_nxt   = base;
        fill_nxt = avail17[15:0];
        if (n_setup == '0) begin
          if (q_room) begin
            push      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          n_nxt     = n_setup;
          i_nxt     = '0;
          addr_nxt  = base[AW-1:0];
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // Issue a read only when its data is sure to find a queue slot
        if ((q_cnt + OQ_CW'(pend_r)) < OQ_CW'(OQ_DEPTH)) begin
          rd_issue = 1'b1;
          addr_nxt = addr_r + AW'(1);
          i_nxt    = i_r + NW'(1);
          if (issue_last) begin
            state_nxt = ST_IDLE;
            if (!peek_r) begin
              rd_nxt   = rd_r + 16'(n_r);
              fill_nxt = fill_r - 16'(n_r);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      fill_r      <= '0;
      cyc_r       <= 1'b1;
      pend_r      <= 1'b0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= rd_issue;
      last_pend_r <= rd_issue && issue_last;
      if (cfg_valid && cfg_ready) begin
        cyc_r <= cfg_cyclic_mode;
      end
    end
  end

  // Burst bookkeeping and captured get arguments
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    addr_r <= addr_nxt;
    if (accept) begin
      count_r <= in_count;
      peek_r  <= in_peek;
    end
  end

  brf_ram #(
    .DATA_W (8),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r[AW-1:0]),
    .wdata (in_data_in),
    .re    (rd_issue),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign pop = out_valid && !out_stall;

  brf_out_fifo u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .cnt       (q_cnt),
    .head_item (head_item)
  );

  assign cfg_ready      = 1'b1;
  assign out_valid      = q_cnt != '0;
  assign out_data_out   = head_item.data;
  assign out_amount     = head_item.amount;
  assign out_byte_valid = head_item.bvalid;
  assign out_last       = head_item.last;

`include "byte_ring_fifo_unit_assert.svh"

  // Fill level register must track the index difference
  `BRF_CHK(a_fill_tracks, clk, rst_n, fill_r == 16'(wr_r - rd_r), "fill level out of step")
  // Result queue must never be pushed when full
  `BRF_CHK_IMP(a_no_q_overflow, clk, rst_n, push, q_cnt < OQ_CW'(OQ_DEPTH), "queue overflow")
  // Store writes never overlap a get burst
  `BRF_CHK_IMP(a_no_wr_in_burst, clk, rst_n, ram_we, !rd_issue && !pend_r, "write in burst")

endmodule
